@@ hw/rtl/fqkr_pkg.sv @@
// Package for the frame queue with keyframe resync.
// Holds op codes, status codes, the default slot count, state, command and status types.
package fqkr_pkg;

    localparam int SLOTS_DEF = 8;

    typedef enum logic [2:0] {
        OP_PUSH     = 3'd0,
        OP_POP      = 3'd1,
        OP_FAIL     = 3'd2,
        OP_NOTE     = 3'd3,
        OP_STAT     = 3'd4,
        OP_SHUTDOWN = 3'd5,
        OP_RSV6     = 3'd6,
        OP_RSV7     = 3'd7
    } op_t;

    typedef enum logic [1:0] {
        ST_DONE    = 2'd0,
        ST_DROPPED = 2'd1,
        ST_STOPPED = 2'd2,
        ST_EMPTY   = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_RESP
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;   // latch the input beat
        logic exec;      // apply the latched operation
        logic respond;   // drive the result beat
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic ready;
    } stat_t;

endpackage

@@ hw/rtl/fqkr_ctrl.sv @@
// Controller for the frame queue: sequences capture, execute and respond.
// Depends on fqkr_pkg.
module fqkr_ctrl
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    input  fqkr_pkg::stat_t dp_stat,
    output logic            busy,
    output fqkr_pkg::cmd_t  cmd
);

    fqkr_pkg::state_t state_reg, state_next;

    // Hold the state register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= fqkr_pkg::S_IDLE;
        else
            state_reg <= state_next;
    end

    // Advance through the three steps of one beat.
    always_comb
    begin
        state_next  = state_reg;
        cmd         = '0;
        busy        = 1'b1;
        unique case (state_reg)
            fqkr_pkg::S_IDLE:
            begin
                busy = 1'b0;
                if (start)
                begin
                    cmd.capture = 1'b1;
                    state_next  = fqkr_pkg::S_EXEC;
                end
            end
            fqkr_pkg::S_EXEC:
            begin
                cmd.exec = 1'b1;
                if (dp_stat.ready)
                    state_next = fqkr_pkg::S_RESP;
            end
            fqkr_pkg::S_RESP:
            begin
                cmd.respond = 1'b1;
                state_next  = fqkr_pkg::S_IDLE;
            end
            default: state_next = fqkr_pkg::S_IDLE;
        endcase
    end

endmodule

@@ hw/rtl/fqkr_dp.sv @@
// Datapath for the frame queue: slot memory, pointers, counters, statistics.
// Depends on fqkr_pkg.
module fqkr_dp
#(
    parameter int SLOTS = fqkr_pkg::SLOTS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  fqkr_pkg::cmd_t        cmd,
    output fqkr_pkg::stat_t       dp_stat,
    input  logic [2:0]            op,
    input  logic [31:0]           frame_len,
    input  logic [31:0]           rtp_stamp,
    input  logic [62:0]           capture_time,
    input  logic [62:0]           enqueue_time,
    input  logic                  is_key,
    input  logic [62:0]           send_start,
    input  logic [62:0]           send_end,
    input  logic                  send_ok,
    input  logic [3:0]            stat_index,
    output logic                  strobe,
    output logic [1:0]            status,
    output logic [31:0]           out_len,
    output logic [31:0]           out_rtp,
    output logic [62:0]           out_capture,
    output logic [62:0]           out_enqueue,
    output logic                  out_key,
    output logic [63:0]           stat_value
);

    localparam int PW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CW = $clog2(SLOTS + 1);
    localparam int SW = 32 + 32 + 63 + 63 + 1;

    // Latched input beat.
    logic [2:0]  op_reg;
    logic [31:0] len_reg, rtp_reg;
    logic [62:0] cap_reg, enq_reg, sst_reg, send_reg;
    logic        key_reg, ok_reg;
    logic [3:0]  idx_reg;

    // Queue state.
    logic [PW-1:0] head_reg, tail_reg;
    logic [CW-1:0] fill_reg;
    logic          await_reg, stopped_reg;
    logic [SW-1:0] mem [SLOTS];
    logic [SW-1:0] rd_reg;

    // Counters and stats.
    logic [31:0] maxd_reg, enqc_reg, deqc_reg, sent_reg, failc_reg, drops_reg;
    logic [63:0] bytes_reg;
    logic [31:0] lastb_reg, maxb_reg;
    logic [62:0] lastq_reg, maxq_reg, lasts_reg, maxs_reg, lastc_reg, maxc_reg;

    // Result registers.
    logic          strobe_reg;
    logic [1:0]    status_reg;
    logic [SW-1:0] pop_reg;
    logic [63:0]   stat_reg;
    logic          step_reg;

    logic [62:0] dq, ds, dc;
    logic [PW-1:0] head_inc, tail_inc;

    assign dq = (sst_reg > enq_reg) ? sst_reg - enq_reg : '0;
    assign ds = (send_reg > sst_reg) ? send_reg - sst_reg : '0;
    assign dc = (send_reg > cap_reg) ? send_reg - cap_reg : '0;
    assign head_inc = (head_reg == PW'(SLOTS - 1)) ? '0 : head_reg + 1'b1;
    assign tail_inc = (tail_reg == PW'(SLOTS - 1)) ? '0 : tail_reg + 1'b1;

    // Execution first reads the tail slot, then applies the operation.
    assign dp_stat.ready = step_reg;

    // Capture the input beat.
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            op_reg   <= op;
            len_reg  <= frame_len;
            rtp_reg  <= rtp_stamp;
            cap_reg  <= capture_time;
            enq_reg  <= enqueue_time;
            key_reg  <= is_key;
            sst_reg  <= send_start;
            send_reg <= send_end;
            ok_reg   <= send_ok;
            idx_reg  <= stat_index;
        end
    end

    // Slot memory: write on push, registered read of the tail slot.
    always_ff @(posedge clk)
    begin
        rd_reg <= mem[tail_reg];
        if (cmd.exec && step_reg && op_reg == fqkr_pkg::OP_PUSH && !stopped_reg
            && !(await_reg && !key_reg) && fill_reg != CW'(SLOTS))
            mem[head_reg] <= {len_reg, rtp_reg, cap_reg, enq_reg, key_reg};
    end

    // Apply the operation and build the result.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg    <= 1'b0;
            head_reg    <= '0;
            tail_reg    <= '0;
            fill_reg    <= '0;
            await_reg   <= 1'b0;
            stopped_reg <= 1'b0;
            maxd_reg    <= '0;
            enqc_reg    <= '0;
            deqc_reg    <= '0;
            sent_reg    <= '0;
            failc_reg   <= '0;
            drops_reg   <= '0;
            bytes_reg   <= '0;
            lastb_reg   <= '0;
            maxb_reg    <= '0;
            lastq_reg   <= '0;
            maxq_reg    <= '0;
            lasts_reg   <= '0;
            maxs_reg    <= '0;
            lastc_reg   <= '0;
            maxc_reg    <= '0;
            strobe_reg  <= 1'b0;
            status_reg  <= fqkr_pkg::ST_DONE;
            pop_reg     <= '0;
            stat_reg    <= '0;
        end
        else
        begin
            strobe_reg <= cmd.respond;
            step_reg   <= cmd.exec && !step_reg;
            if (cmd.exec && step_reg)
            begin
                status_reg <= fqkr_pkg::ST_DONE;
                pop_reg    <= '0;
                stat_reg   <= '0;
                unique case (fqkr_pkg::op_t'(op_reg))
                    fqkr_pkg::OP_PUSH:
                    begin
                        if (stopped_reg)
                            status_reg <= fqkr_pkg::ST_STOPPED;
                        else if (await_reg && !key_reg)
                            status_reg <= fqkr_pkg::ST_DROPPED;
                        else if (fill_reg == CW'(SLOTS))
                        begin
                            drops_reg  <= drops_reg + 32'(fill_reg) + 32'd1;
                            fill_reg   <= '0;
                            tail_reg   <= head_reg;
                            await_reg  <= 1'b1;
                            status_reg <= fqkr_pkg::ST_DROPPED;
                        end
                        else
                        begin
                            await_reg <= 1'b0;
                            head_reg  <= head_inc;
                            fill_reg  <= fill_reg + 1'b1;
                            enqc_reg  <= enqc_reg + 32'd1;
                            if (32'(fill_reg) + 32'd1 > maxd_reg)
                                maxd_reg <= 32'(fill_reg) + 32'd1;
                        end
                    end
                    fqkr_pkg::OP_POP:
                    begin
                        if (stopped_reg)
                            status_reg <= fqkr_pkg::ST_STOPPED;
                        else if (fill_reg == '0)
                            status_reg <= fqkr_pkg::ST_EMPTY;
                        else
                        begin
                            pop_reg  <= rd_reg;
                            tail_reg <= tail_inc;
                            fill_reg <= fill_reg - 1'b1;
                            deqc_reg <= deqc_reg + 32'd1;
                        end
                    end
                    fqkr_pkg::OP_FAIL:
                    begin
                        if (stopped_reg)
                            status_reg <= fqkr_pkg::ST_STOPPED;
                        else
                        begin
                            drops_reg <= drops_reg + 32'(fill_reg) + 32'd1;
                            fill_reg  <= '0;
                            tail_reg  <= head_reg;
                            await_reg <= 1'b1;
                        end
                    end
                    fqkr_pkg::OP_NOTE:
                    begin
                        if (ok_reg)
                        begin
                            sent_reg  <= sent_reg + 32'd1;
                            bytes_reg <= bytes_reg + 64'(len_reg);
                        end
                        else
                            failc_reg <= failc_reg + 32'd1;
                        lastb_reg <= len_reg;
                        if (len_reg > maxb_reg)
                            maxb_reg <= len_reg;
                        lastq_reg <= dq;
                        if (dq > maxq_reg)
                            maxq_reg <= dq;
                        lasts_reg <= ds;
                        if (ds > maxs_reg)
                            maxs_reg <= ds;
                        lastc_reg <= dc;
                        if (dc > maxc_reg)
                            maxc_reg <= dc;
                    end
                    fqkr_pkg::OP_STAT:
                    begin
                        unique case (idx_reg)
                            4'd0:    stat_reg <= 64'(fill_reg);
                            4'd1:    stat_reg <= 64'(maxd_reg);
                            4'd2:    stat_reg <= 64'(enqc_reg);
                            4'd3:    stat_reg <= 64'(deqc_reg);
                            4'd4:    stat_reg <= 64'(sent_reg);
                            4'd5:    stat_reg <= 64'(failc_reg);
                            4'd6:    stat_reg <= 64'(drops_reg);
                            4'd7:    stat_reg <= bytes_reg;
                            4'd8:    stat_reg <= 64'(lastb_reg);
                            4'd9:    stat_reg <= 64'(maxb_reg);
                            4'd10:   stat_reg <= 64'(lastq_reg);
                            4'd11:   stat_reg <= 64'(maxq_reg);
                            4'd12:   stat_reg <= 64'(lasts_reg);
                            4'd13:   stat_reg <= 64'(maxs_reg);
                            4'd14:   stat_reg <= 64'(lastc_reg);
                            default: stat_reg <= 64'(maxc_reg);
                        endcase
                    end
                    fqkr_pkg::OP_SHUTDOWN: stopped_reg <= 1'b1;
                    default: ;
                endcase
            end
        end
    end

    assign strobe      = strobe_reg;
    assign status      = status_reg;
    assign out_len     = pop_reg[SW-1 -: 32];
    assign out_rtp     = pop_reg[SW-33 -: 32];
    assign out_capture = pop_reg[126:64];
    assign out_enqueue = pop_reg[63:1];
    assign out_key     = pop_reg[0];
    assign stat_value  = stat_reg;

endmodule

@@ hw/rtl/frame_queue_keyframe_resync_core.sv @@
// Frame queue with keyframe resync: a command is taken when start is high
// and busy is low; it then runs the execute steps (read the tail slot, then
// apply) and the respond step, and strobe, registered from respond, marks
// its result beat. No new command is taken before the previous one has left
// the respond step, as busy is high until then. The receiver cannot stall.
// Reset (rst_n, async, low) empties the queue and clears all counters.
module frame_queue_keyframe_resync_core
#(
    parameter int SLOTS = fqkr_pkg::SLOTS_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [2:0]  op,
    input  logic [31:0] frame_len,
    input  logic [31:0] rtp_stamp,
    input  logic [62:0] capture_time,
    input  logic [62:0] enqueue_time,
    input  logic        is_key,
    input  logic [62:0] send_start,
    input  logic [62:0] send_end,
    input  logic        send_ok,
    input  logic [3:0]  stat_index,
    output logic        strobe,
    output logic [1:0]  status,
    output logic [31:0] out_len,
    output logic [31:0] out_rtp,
    output logic [62:0] out_capture,
    output logic [62:0] out_enqueue,
    output logic        out_key,
    output logic [63:0] stat_value
);

    fqkr_pkg::cmd_t  cmd;
    fqkr_pkg::stat_t dp_stat;

    fqkr_ctrl u_ctrl
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .dp_stat (dp_stat),
        .busy    (busy),
        .cmd     (cmd)
    );

    fqkr_dp #(.SLOTS(SLOTS)) u_dp
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .dp_stat      (dp_stat),
        .op           (op),
        .frame_len    (frame_len),
        .rtp_stamp    (rtp_stamp),
        .capture_time (capture_time),
        .enqueue_time (enqueue_time),
        .is_key       (is_key),
        .send_start   (send_start),
        .send_end     (send_end),
        .send_ok      (send_ok),
        .stat_index   (stat_index),
        .strobe       (strobe),
        .status       (status),
        .out_len      (out_len),
        .out_rtp      (out_rtp),
        .out_capture  (out_capture),
        .out_enqueue  (out_enqueue),
        .out_key      (out_key),
        .stat_value   (stat_value)
    );

`ifndef SYNTHESIS
    // A result beat only follows a respond step.
    assert property (@(posedge clk) disable iff (!rst_n)
        strobe |-> $past(cmd.respond))
        else $error("strobe without respond");
    // An accepted command makes the block busy next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("busy not raised after accept");
    // No strobe right after an accept.
    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> !strobe)
        else $error("strobe too early");
`endif

endmodule
